### rtl/core/mbpm_pkg.sv
package mbpm_pkg;

   localparam int MaxPatternBytesDefault = 16;
   localparam int OffsetBitsDefault      = 32;

   localparam int ByteWidth      = 8;
   localparam int RegWidth       = 64;
   localparam int LenWidth       = 5;
   localparam int LaneIndexWidth = 4;
   localparam int LaneCount      = 16;
   localparam int OffsetWidth    = 32;
   localparam int CsrIndexWidth  = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MASK_LOW     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MASK_HIGH    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PATTERN_LEN  = 3'd4;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

### rtl/core/mbpm_cell.sv
module mbpm_cell
   import mbpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [ByteWidth-1:0] shift_in,
   input  logic [ByteWidth-1:0] lane_pattern,
   input  logic [ByteWidth-1:0] lane_mask,
   input  logic                 lane_on,
   output logic [ByteWidth-1:0] byte_out,
   output logic                 hit
);

   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;

   // compare the byte about to enter this cell, i.e. the post-shift window
   assign hit = !lane_on || (((shift_in ^ lane_pattern) & ~lane_mask) == '0);

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.shift) begin
         byte_in = ctrl.clear ? '0 : shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

### rtl/core/masked_byte_pattern_matcher.sv
// A matching byte's offset shows on rsp_ in the cycle after the byte is accepted.
// Throughput: one byte per cycle while req_stall is low; the masked window compare runs in parallel across
// the row of window cells, and the output register lets a new byte in while it is taken.
// Reset (synchronous): window and byte count cleared, pattern and mask zero,
// pattern length one, no result pending.
module masked_byte_pattern_matcher
   import mbpm_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MaxPatternBytesDefault,
   parameter int OFFSET_BITS       = OffsetBitsDefault
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ByteWidth-1:0]     req_data_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OffsetWidth-1:0]   rsp_match_offset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]      csr_write_data
);

   logic [RegWidth-1:0]    pattern_low_ff;
   logic [RegWidth-1:0]    pattern_high_ff;
   logic [RegWidth-1:0]    mask_low_ff;
   logic [RegWidth-1:0]    mask_high_ff;
   logic [LenWidth-1:0]    pattern_len_ff;

   logic [OFFSET_BITS-1:0] seen_ff;
   logic [OFFSET_BITS-1:0] seen_in;
   logic [OFFSET_BITS-1:0] seen_next;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [OffsetWidth-1:0] rsp_offset_ff;
   logic [OffsetWidth-1:0] rsp_offset_in;

   logic                   req_accept;
   logic [LenWidth-1:0]    active_len;
   logic                   window_full;
   logic                   hit;
   logic [63:0]            offset_wide;
   cell_ctrl_type          cell_ctrl;

   logic [ByteWidth-1:0]   pat_bytes  [LaneCount];
   logic [ByteWidth-1:0]   mask_bytes [LaneCount];
   logic [ByteWidth-1:0]   cell_byte  [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] cell_hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         mask_low_ff     <= '0;
         mask_high_ff    <= '0;
         pattern_len_ff  <= LenWidth'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_write_data;
            CSR_MASK_LOW:     mask_low_ff     <= csr_write_data;
            CSR_MASK_HIGH:    mask_high_ff    <= csr_write_data;
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_write_data[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   // clamp length into 1..MAX_PATTERN_BYTES
   always_comb begin
      active_len = pattern_len_ff;
      if (pattern_len_ff == '0) begin
         active_len = LenWidth'(1);
      end else if (pattern_len_ff > LenWidth'(MAX_PATTERN_BYTES)) begin
         active_len = LenWidth'(MAX_PATTERN_BYTES);
      end
   end

   always_comb begin
      for (int k = 0; k < LaneCount / 2; k++) begin
         pat_bytes[k]                 = pattern_low_ff[k*ByteWidth +: ByteWidth];
         pat_bytes[k + LaneCount/2]   = pattern_high_ff[k*ByteWidth +: ByteWidth];
         mask_bytes[k]                = mask_low_ff[k*ByteWidth +: ByteWidth];
         mask_bytes[k + LaneCount/2]  = mask_high_ff[k*ByteWidth +: ByteWidth];
      end
   end

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign cell_ctrl.shift = req_accept;
   assign cell_ctrl.clear = req_last_byte;

   // window cell i holds the i-th newest byte and checks pattern byte len-1-i
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      logic [ByteWidth-1:0]      shift_in;
      logic [LaneIndexWidth-1:0] lane_idx;
      logic                      lane_on;

      if (i == 0) begin : g_head
         assign shift_in = req_data_byte;
      end else begin : g_body
         assign shift_in = cell_byte[i-1];
      end

      assign lane_on  = LenWidth'(i) < active_len;
      assign lane_idx = LaneIndexWidth'(active_len - LenWidth'(i) - LenWidth'(1));

      mbpm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .shift_in     (shift_in),
         .lane_pattern (pat_bytes[lane_idx]),
         .lane_mask    (mask_bytes[lane_idx]),
         .lane_on      (lane_on),
         .byte_out     (cell_byte[i]),
         .hit          (cell_hit[i])
      );
   end

   // saturating byte count of the current buffer
   assign seen_next   = (&seen_ff) ? seen_ff : seen_ff + OFFSET_BITS'(1);
   assign window_full = seen_next >= OFFSET_BITS'(active_len);
   assign hit         = window_full && (&cell_hit);
   assign offset_wide = 64'(seen_next - OFFSET_BITS'(active_len));

   always_comb begin
      seen_in = seen_ff;
      if (req_accept) begin
         seen_in = req_last_byte ? '0 : seen_next;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_offset_in = rsp_offset_ff;
      if (req_accept && hit) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = offset_wide[OffsetWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = rsp_offset_ff;

   a_last_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> seen_ff == '0)
      else $error("byte count not cleared after last byte");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no pending result");

   a_hit_needs_full_window: assert property (@(posedge clock) disable iff (reset)
      req_accept && hit |-> seen_next >= OFFSET_BITS'(active_len))
      else $error("match reported before window filled");

   a_hit_loads_output: assert property (@(posedge clock) disable iff (reset)
      req_accept && hit |=> rsp_valid_ff)
      else $error("match dropped");

endmodule
